>>> hdl/lsb_message_extract_defines.svh
// Assertion helpers shared by the RTL; empty when building for synthesis.
`ifndef LSB_MESSAGE_EXTRACT_DEFINES_SVH
`define LSB_MESSAGE_EXTRACT_DEFINES_SVH

`ifndef SYNTHESIS
// Check cons in the same cycle whenever ante holds.
`define LME_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lsb_message_extract: same-cycle check failed");
// Check cons in the cycle after ante holds.
`define LME_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lsb_message_extract: next-cycle check failed");
`else
`define LME_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LME_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/lme_pkg.sv
`default_nettype none
package lme_pkg;

	// Decoder phase
	typedef enum logic [1:0] {
		PH_MARKER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_TEXT   = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	// Result codes
	typedef enum logic [1:0] {
		KIND_BYTE   = 2'd0,
		KIND_LENGTH = 2'd1,
		KIND_NOMSG  = 2'd2,
		KIND_TRUNC  = 2'd3
	} kind_t;

	localparam int unsigned LANES = 3;
	localparam logic [5:0] MARKER_BITS = 6'd24;
	localparam logic [5:0] HEADER_BITS = 6'd56;
	localparam logic [23:0] MARKER_RESET = 24'hE29DA4;

	// Output queue: two results may enter per pixel
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		phase_t      phase;
		logic [5:0]  hdr_cnt;
		logic [31:0] hdr_sh;
		logic [7:0]  byte_sh;
		logic [2:0]  byte_cnt;
		logic [31:0] remain;
	} dec_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic        last;
	} res_t;

	typedef struct packed {
		logic hit;
		res_t res;
	} lane_out_t;

	typedef struct packed {
		logic [QCNT_W-1:0] count;
		logic              room;
	} q_stat_t;

endpackage
`default_nettype wire

>>> hdl/lme_pix_if.sv
`default_nettype none
interface lme_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       first_pixel;
	logic       last_pixel;

	modport source (output valid, red, green, blue, first_pixel, last_pixel, input ready);
	modport sink (input valid, red, green, blue, first_pixel, last_pixel, output ready);
endinterface
`default_nettype wire

>>> hdl/lme_res_if.sv
`default_nettype none
interface lme_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] value;
	logic        last;

	modport source (output valid, kind, value, last, input ready);
	modport sink (input valid, kind, value, last, output ready);
endinterface
`default_nettype wire

>>> hdl/lme_lane.sv
`default_nettype none
module lme_lane (
	input  lme_pkg::dec_state_t st_in,
	input  logic                bit_in,
	input  logic [23:0]         marker,
	output lme_pkg::dec_state_t st_out,
	output lme_pkg::lane_out_t  lane_res
);
	import lme_pkg::*;

	// Advance the decoder by one stream bit
	always_comb begin
		st_out   = st_in;
		lane_res = '0;
		unique case (st_in.phase)
			PH_MARKER, PH_LENGTH: begin
				st_out.hdr_sh  = {st_in.hdr_sh[30:0], bit_in};
				st_out.hdr_cnt = st_in.hdr_cnt + 6'd1;
				if (st_in.phase == PH_MARKER && st_out.hdr_cnt == MARKER_BITS) begin
					if (st_out.hdr_sh[23:0] != marker) begin
						lane_res.hit       = 1'b1;
						lane_res.res.kind  = KIND_NOMSG;
						lane_res.res.value = 32'd0;
						lane_res.res.last  = 1'b1;
						st_out.phase       = PH_DONE;
					end else begin
						st_out.phase = PH_LENGTH;
					end
				end else if (st_in.phase == PH_LENGTH && st_out.hdr_cnt == HEADER_BITS) begin
					st_out.remain      = st_out.hdr_sh;
					lane_res.hit       = 1'b1;
					lane_res.res.kind  = KIND_LENGTH;
					lane_res.res.value = st_out.hdr_sh;
					if (st_out.hdr_sh == 32'd0) begin
						lane_res.res.last = 1'b1;
						st_out.phase      = PH_DONE;
					end else begin
						lane_res.res.last = 1'b0;
						st_out.phase      = PH_TEXT;
					end
				end
			end
			PH_TEXT: begin
				st_out.byte_sh  = {st_in.byte_sh[6:0], bit_in};
				st_out.byte_cnt = st_in.byte_cnt + 3'd1;
				// Emit the byte on its eighth bit
				if (st_in.byte_cnt == 3'd7) begin
					st_out.remain      = st_in.remain - 32'd1;
					lane_res.hit       = 1'b1;
					lane_res.res.kind  = KIND_BYTE;
					lane_res.res.value = {24'd0, st_out.byte_sh};
					lane_res.res.last  = (st_in.remain == 32'd1);
					if (st_in.remain == 32'd1) begin
						st_out.phase = PH_DONE;
					end
				end
			end
			PH_DONE: begin
			end
		endcase
	end

endmodule
`default_nettype wire

>>> hdl/lme_merge.sv
`default_nettype none
module lme_merge (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  lme_pkg::lane_out_t [lme_pkg::LANES-1:0] lane_res,
	input  lme_pkg::lane_out_t                end_res,
	lme_res_if.source                         res,
	output lme_pkg::q_stat_t                  stat
);
	import lme_pkg::*;

	res_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] count_q;

	lane_out_t  lane_m;
	res_t       e0;
	res_t       e1;
	logic [1:0] n_push;
	logic       pop;

	// Combine the lanes; at most one lane hits per pixel
	always_comb begin
		lane_m = '0;
		for (int i = 0; i < LANES; i++) begin
			if (lane_res[i].hit) begin
				lane_m = lane_res[i];
			end
		end
	end

	// Order lane result before the end-of-image result
	always_comb begin
		e0 = lane_m.hit ? lane_m.res : end_res.res;
		e1 = end_res.res;
		n_push = 2'd0;
		if (push) begin
			n_push = {1'b0, lane_m.hit} + {1'b0, end_res.hit};
		end
	end

	assign pop = res.valid & res.ready;

	// Store queued results
	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			mem_q[wr_q] <= e0;
		end
		if (n_push == 2'd2) begin
			mem_q[wr_q + QPTR_W'(1)] <= e1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_W'(n_push);
			rd_q    <= rd_q + QPTR_W'(pop);
			count_q <= count_q + QCNT_W'(n_push) - QCNT_W'(pop);
		end
	end

	assign res.valid  = (count_q != '0);
	assign res.kind   = mem_q[rd_q].kind;
	assign res.value  = mem_q[rd_q].value;
	assign res.last   = mem_q[rd_q].last;

	assign stat.count = count_q;
	assign stat.room  = (count_q <= QCNT_W'(QDEPTH - 2));

endmodule
`default_nettype wire

>>> hdl/lsb_message_extract.sv
// Hidden-message reader. Takes pixels on pix and pulls bit 0 of red, green
// and blue, in that order, into an MSB-first stream. The first 24 bits must
// equal the marker register, the next 32 give the message length in bytes
// (reported as a length result), and the following bits are delivered as
// text bytes, the final one flagged last. A mismatch or an image that ends
// early closes the image with a no-message or truncated result; first_pixel
// restarts decoding. Three decoder lanes, one per color, handle a pixel
// combinationally, so a pixel is taken every clock while pix.ready is high;
// results are registered in a four-entry output queue that drives res and
// sets when pix.ready drops: it falls only while more than two results wait,
// that is, while res is held off. Write marker only while the block is idle.
`default_nettype none
`include "lsb_message_extract_defines.svh"
module lsb_message_extract (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        marker_we,
	input  logic [23:0] marker_wdata,
	lme_pix_if.sink     pix,
	lme_res_if.source   res
);
	import lme_pkg::*;

	logic [23:0]                marker_q;
	dec_state_t                 dec_q;
	dec_state_t                 st_chain [LANES+1];
	logic [LANES-1:0]           lane_bit;
	lane_out_t [LANES-1:0]      lane_res;
	logic [LANES-1:0]           lane_hit;
	lane_out_t                  end_res;
	dec_state_t                 dec_next;
	q_stat_t                    stat;
	logic                       accept;

	assign accept   = pix.valid & pix.ready;
	assign pix.ready = stat.room;

	// Hold the marker register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_q <= MARKER_RESET;
		end else if (marker_we) begin
			marker_q <= marker_wdata;
		end
	end

	// Restart on the first pixel of an image
	always_comb begin
		st_chain[0] = dec_q;
		if (pix.first_pixel) begin
			st_chain[0]       = '0;
			st_chain[0].phase = PH_MARKER;
		end
	end

	assign lane_bit[0] = pix.red[0];
	assign lane_bit[1] = pix.green[0];
	assign lane_bit[2] = pix.blue[0];

	// One lane per color bit, chained in stream order
	for (genvar g = 0; g < LANES; g++) begin : g_lane
		lme_lane u_lane (
			.st_in    (st_chain[g]),
			.bit_in   (lane_bit[g]),
			.marker   (marker_q),
			.st_out   (st_chain[g+1]),
			.lane_res (lane_res[g])
		);
		assign lane_hit[g] = lane_res[g].hit;
	end

	// Close the image when it ends undecided
	always_comb begin
		dec_next = st_chain[LANES];
		end_res  = '0;
		if (pix.last_pixel && st_chain[LANES].phase != PH_DONE) begin
			end_res.hit       = 1'b1;
			end_res.res.kind  = (st_chain[LANES].phase == PH_MARKER) ? KIND_NOMSG : KIND_TRUNC;
			end_res.res.value = 32'd0;
			end_res.res.last  = 1'b1;
			dec_next.phase    = PH_DONE;
		end
	end

	// Advance decoder state on each pixel transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_q       <= '0;
			dec_q.phase <= PH_MARKER;
		end else if (accept) begin
			dec_q <= dec_next;
		end
	end

	lme_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.lane_res (lane_res),
		.end_res  (end_res),
		.res      (res),
		.stat     (stat)
	);

	`LME_ASSERT_SAME(a_queue_bound, clk, arst_n, 1'b1, stat.count <= QCNT_W'(QDEPTH))
	`LME_ASSERT_SAME(a_one_lane_hit, clk, arst_n, accept, $onehot0(lane_hit))
	`LME_ASSERT_NEXT(a_last_closes, clk, arst_n, accept && pix.last_pixel, dec_q.phase == PH_DONE)

endmodule
`default_nettype wire
